// File: rtl/core/nnls_pkg.sv
// shared types, codes and saturating q32.32 helpers for the nnls solver
// no dependencies
`default_nettype none
package nnls_pkg;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_SOLVE  = 2'd2;

	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_SOLVE  = 2'd2;

	localparam logic [1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [1:0] REG_NUM_COLS = 2'd1;
	localparam logic [1:0] REG_MAX_ITER = 2'd2;
	localparam logic [1:0] REG_TOL      = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QA     = 2;

	localparam logic signed [63:0] FX_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] FX_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [5:0]        row;
		logic [4:0]        col;
		logic signed [63:0] value;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  num_rows;
		logic [5:0]  num_cols;
		logic [15:0] max_iterations;
		logic [31:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic              sat;
		logic signed [63:0] val;
	} fx_res_t;

	function automatic fx_res_t fx_add(logic signed [63:0] a, logic signed [63:0] b);
		fx_res_t o;
		logic signed [63:0] r;
		r = a + b;
		o.sat = 1'b0;
		o.val = r;
		if (a[63] == b[63] && r[63] != a[63]) begin
			o.sat = 1'b1;
			o.val = a[63] ? FX_MIN : FX_MAX;
		end
		return o;
	endfunction

	function automatic fx_res_t fx_sub(logic signed [63:0] a, logic signed [63:0] b);
		fx_res_t o;
		logic signed [63:0] r;
		r = a - b;
		o.sat = 1'b0;
		o.val = r;
		if (a[63] != b[63] && r[63] != a[63]) begin
			o.sat = 1'b1;
			o.val = a[63] ? FX_MIN : FX_MAX;
		end
		return o;
	endfunction

	function automatic fx_res_t fx_neg(logic signed [63:0] a);
		fx_res_t o;
		o.sat = (a == FX_MIN);
		o.val = (a == FX_MIN) ? FX_MAX : -a;
		return o;
	endfunction

	// magnitude plus sign back to signed, saturating
	function automatic fx_res_t fx_sign(logic [63:0] m, logic neg, logic over);
		fx_res_t o;
		logic [63:0] limit;
		limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (over || m > limit) begin
			o.sat = 1'b1;
			o.val = neg ? FX_MIN : FX_MAX;
		end else begin
			o.sat = 1'b0;
			o.val = neg ? -$signed(m) : $signed(m);
		end
		return o;
	endfunction

	function automatic logic [63:0] fx_mag(logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/nnls_front.sv
// front end: accepts stream words, drops ignored ones, queues commands
// depends on nnls_pkg
`default_nettype none
module nnls_front import nnls_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // row[5:0], col[10:6], value[74:11], zero fill
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic             q_valid,
	output cmd_t             q_item,
	input  wire logic        q_pop
);

	cmd_t         entry_q [QDEPTH];
	logic [QA-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA:0]   count_q;
	logic          take, keep;
	cmd_t          cmd;

	always_comb begin
		cmd.row   = s_axis_tdata[5:0];
		cmd.col   = s_axis_tdata[10:6];
		cmd.value = $signed(s_axis_tdata[74:11]);
		cmd.kind  = KIND_SOLVE;
		keep      = 1'b0;
		case (s_axis_tuser)
			OP_LOAD_A: begin
				cmd.kind = KIND_LOAD_A;
				keep = (int'(cmd.row) < MAX_ROWS) && (int'(cmd.col) < MAX_COLS);
			end
			OP_LOAD_B: begin
				cmd.kind = KIND_LOAD_B;
				keep = int'(cmd.row) < MAX_ROWS;
			end
			OP_SOLVE: begin
				cmd.kind = KIND_SOLVE;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign s_axis_tready = count_q != (QA+1)'(QDEPTH);
	assign take    = s_axis_tvalid && s_axis_tready && keep;
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (take) entry_q[wr_ptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QA+1)'(take) - (QA+1)'(q_pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nnls_mul.sv
// q32.32 saturating multiplier, one 32x32 partial product per cycle
// depends on nnls_pkg
`default_nettype none
module nnls_mul import nnls_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic                   done,
	output fx_res_t                res
);

	logic [63:0] ua_q, ub_q;
	logic        neg_q, busy_q, done_q;
	logic [2:0]  step_q;
	logic [63:0] p00_q, p01_q, p10_q, p11_q;
	logic [63:0] whole_q;
	logic        over_q;
	fx_res_t     res_q;
	logic [31:0] opa, opb;
	logic [63:0] prod;
	logic [33:0] mid;
	logic [63:0] hi;

	always_comb begin
		opa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
		opb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
		prod = 64'(opa) * 64'(opb);
		mid = 34'(p00_q[63:32]) + 34'(p01_q[31:0]) + 34'(p10_q[31:0]);
		hi  = p11_q + 64'(p01_q[63:32]) + 64'(p10_q[63:32]) + 64'(mid[33:32]);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= fx_mag(a);
			ub_q  <= fx_mag(b);
			neg_q <= a[63] ^ b[63];
		end
		if (busy_q) begin
			case (step_q)
				3'd0: p00_q <= prod;
				3'd1: p01_q <= prod;
				3'd2: p10_q <= prod;
				3'd3: p11_q <= prod;
				3'd4: begin
					whole_q <= {hi[31:0], mid[31:0]};
					over_q  <= hi[63:32] != '0;
				end
				default: res_q <= fx_sign(whole_q, neg_q, over_q);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: rtl/core/nnls_div.sv
// q32.32 saturating divider, radix 2, one quotient bit per cycle
// depends on nnls_pkg
`default_nettype none
module nnls_div import nnls_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [63:0] den,
	output logic                   done,
	output fx_res_t                res
);

	logic [63:0] rem_q, sh_q, ud_q, quo_q;
	logic        neg_q, ovf_q, busy_q, fin_q, done_q;
	logic [5:0]  cnt_q;
	fx_res_t     res_q;
	logic [63:0] un, ud;
	logic [64:0] remx;
	logic        ge;

	always_comb begin
		un   = fx_mag(num);
		ud   = fx_mag(den);
		remx = {rem_q, sh_q[63]};
		ge   = remx >= {1'b0, ud_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {32'b0, un[63:32]};
			sh_q  <= {un[31:0], 32'b0};
			ud_q  <= ud;
			neg_q <= num[63] ^ den[63];
			ovf_q <= {32'b0, un[63:32]} >= ud;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(remx - {1'b0, ud_q}) : remx[63:0];
			sh_q  <= {sh_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
		if (fin_q) begin
			if (ovf_q) begin
				res_q.sat <= 1'b1;
				res_q.val <= neg_q ? FX_MIN : FX_MAX;
			end else begin
				res_q <= fx_sign(quo_q, neg_q, 1'b0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: rtl/core/nnls_engine.sv
// back end: stores, gram forming, coordinate sweeps and result output
// depends on nnls_pkg, nnls_mul, nnls_div
`default_nettype none
module nnls_engine import nnls_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	input  wire cmd_t        q_item,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,
	output logic             m_tlast
);

	localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MAT_DEPTH  = MAX_ROWS << CA;
	localparam int GRAM_DEPTH = 1 << (2 * CA);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_G_RD  = 4'd1;
	localparam logic [3:0] ST_G_MUL = 4'd2;
	localparam logic [3:0] ST_G_MW  = 4'd3;
	localparam logic [3:0] ST_S_RD  = 4'd4;
	localparam logic [3:0] ST_S_PIV = 4'd5;
	localparam logic [3:0] ST_S_DW  = 4'd6;
	localparam logic [3:0] ST_S_T   = 4'd7;
	localparam logic [3:0] ST_S_NXT = 4'd8;
	localparam logic [3:0] ST_U_RD  = 4'd9;
	localparam logic [3:0] ST_U_MUL = 4'd10;
	localparam logic [3:0] ST_U_MW  = 4'd11;
	localparam logic [3:0] ST_O_RD  = 4'd12;
	localparam logic [3:0] ST_O_EM  = 4'd13;

	logic signed [63:0] mat_mem  [MAT_DEPTH];
	logic signed [63:0] rhs_mem  [MAX_ROWS];
	logic signed [63:0] gram_mem [GRAM_DEPTH];
	logic signed [63:0] grad_mem [MAX_COLS];
	logic signed [63:0] sol_mem  [MAX_COLS];

	logic [3:0]    state_q;
	logic [RA-1:0] r_q, rlast_q;
	logic [CA-1:0] i_q, j_q, clast_q;
	logic          gp_q;
	logic [15:0]   maxit_q, iter_q;
	logic [31:0]   tol_q;
	logic signed [63:0] acc_q, x_q, t_q, delta_q, gq_q;
	logic [63:0]   maxchg_q;
	logic          sat_q, zp_q, conv_q;

	logic signed [63:0] mat0_q, mat1_q, rhs_q, gram_q, grad_q, sol_q;

	logic          m_valid_q, m_last_q;
	logic [87:0]   m_data_q;

	logic          mul_start, mul_done, div_start, div_done;
	logic signed [63:0] mul_a, mul_b;
	fx_res_t       mul_res, div_res;

	logic          gram_we, grad_we, sol_we;
	logic [2*CA-1:0] gram_waddr, gram_raddr;
	logic [CA-1:0] grad_waddr, grad_raddr, sol_waddr, sol_raddr;
	logic signed [63:0] gram_wdata, grad_wdata, sol_wdata;

	fx_res_t       accn, negn, subn, dltn, updn;
	logic [63:0]   chg;
	logic          out_load;
	logic [15:0]   iter_n;
	logic [6:0]    nr_c;
	logic [5:0]    nc_c;

	nnls_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	nnls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (grad_q),
		.den    (gram_q),
		.done   (div_done),
		.res    (div_res)
	);

	always_comb begin
		nr_c = (cfg.num_rows == '0) ? 7'd1 :
			((int'(cfg.num_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.num_rows);
		nc_c = (cfg.num_cols == '0) ? 6'd1 :
			((int'(cfg.num_cols) > MAX_COLS) ? 6'(MAX_COLS) : cfg.num_cols);
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign mul_start = (state_q == ST_G_MUL) || (state_q == ST_U_MUL);
	assign mul_a     = (state_q == ST_U_MUL) ? delta_q : mat0_q;
	assign mul_b     = (state_q == ST_U_MUL) ? gram_q : (gp_q ? mat1_q : rhs_q);
	assign div_start = (state_q == ST_S_PIV) && (gram_q != '0);
	assign out_load  = (state_q == ST_O_EM) && (!m_valid_q || m_tready);

	always_comb begin
		accn   = fx_add(acc_q, mul_res.val);
		negn   = fx_neg(accn.val);
		subn   = fx_sub(x_q, div_res.val);
		dltn   = fx_sub(t_q, x_q);
		updn   = fx_add(gq_q, mul_res.val);
		chg    = (t_q >= x_q) ? 64'(t_q - x_q) : 64'(x_q - t_q);
		iter_n = iter_q + 1'b1;

		gram_raddr = (state_q == ST_U_RD) ? {j_q, i_q} : {i_q, i_q};
		grad_raddr = (state_q == ST_U_RD) ? j_q : i_q;
		sol_raddr  = (state_q == ST_O_RD || state_q == ST_O_EM) ? j_q : i_q;

		gram_we    = (state_q == ST_G_MW) && mul_done && (r_q == rlast_q) && gp_q;
		gram_waddr = {i_q, j_q};
		gram_wdata = accn.val;

		grad_we    = 1'b0;
		grad_waddr = i_q;
		grad_wdata = negn.val;
		if ((state_q == ST_G_MW) && mul_done && (r_q == rlast_q) && !gp_q) begin
			grad_we = 1'b1;
		end else if ((state_q == ST_U_MW) && mul_done) begin
			grad_we    = 1'b1;
			grad_waddr = j_q;
			grad_wdata = updn.val;
		end

		sol_we    = 1'b0;
		sol_waddr = i_q;
		sol_wdata = '0;
		if ((state_q == ST_G_MW) && mul_done && (r_q == rlast_q) && !gp_q) begin
			sol_we = 1'b1;
		end else if (state_q == ST_S_T) begin
			sol_we    = 1'b1;
			sol_wdata = t_q;
		end
	end

	// stores, all reads registered
	always_ff @(posedge clk) begin
		if (q_pop && q_item.kind == KIND_LOAD_A)
			mat_mem[{RA'(q_item.row), CA'(q_item.col)}] <= q_item.value;
		if (q_pop && q_item.kind == KIND_LOAD_B)
			rhs_mem[RA'(q_item.row)] <= q_item.value;
		if (gram_we) gram_mem[gram_waddr] <= gram_wdata;
		if (grad_we) grad_mem[grad_waddr] <= grad_wdata;
		if (sol_we)  sol_mem[sol_waddr]   <= sol_wdata;
		mat0_q <= mat_mem[{r_q, i_q}];
		mat1_q <= mat_mem[{r_q, j_q}];
		rhs_q  <= rhs_mem[r_q];
		gram_q <= gram_mem[gram_raddr];
		grad_q <= grad_mem[grad_raddr];
		sol_q  <= sol_mem[sol_raddr];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {1'b0, sat_q, zp_q, iter_q, conv_q, sol_q[62:0], 5'(j_q)};
			m_last_q <= j_q == clast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			r_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			rlast_q   <= '0;
			clast_q   <= '0;
			gp_q      <= 1'b1;
			maxit_q   <= '0;
			iter_q    <= '0;
			tol_q     <= '0;
			acc_q     <= '0;
			x_q       <= '0;
			t_q       <= '0;
			delta_q   <= '0;
			gq_q      <= '0;
			maxchg_q  <= '0;
			sat_q     <= 1'b0;
			zp_q      <= 1'b0;
			conv_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_tready) m_valid_q <= 1'b0;
			if (out_load) m_valid_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.kind == KIND_SOLVE) begin
						rlast_q <= RA'(nr_c - 7'd1);
						clast_q <= CA'(nc_c - 6'd1);
						maxit_q <= (cfg.max_iterations == '0) ? 16'd1 : cfg.max_iterations;
						tol_q   <= cfg.tolerance;
						r_q     <= '0;
						i_q     <= '0;
						j_q     <= '0;
						gp_q    <= 1'b1;
						acc_q   <= '0;
						iter_q  <= '0;
						sat_q   <= 1'b0;
						zp_q    <= 1'b0;
						conv_q  <= 1'b0;
						state_q <= ST_G_RD;
					end
				end
				ST_G_RD:  state_q <= ST_G_MUL;
				ST_G_MUL: state_q <= ST_G_MW;
				ST_G_MW: begin
					if (mul_done) begin
						sat_q <= sat_q | mul_res.sat | accn.sat;
						if (r_q != rlast_q) begin
							acc_q <= accn.val;
							r_q   <= r_q + 1'b1;
						end else begin
							acc_q <= '0;
							r_q   <= '0;
							if (gp_q) begin
								if (i_q == j_q && accn.val == '0) zp_q <= 1'b1;
								if (j_q == clast_q) gp_q <= 1'b0;
								else j_q <= j_q + 1'b1;
							end else begin
								if (negn.sat) sat_q <= 1'b1;
								gp_q <= 1'b1;
								j_q  <= '0;
								if (i_q == clast_q) begin
									i_q      <= '0;
									maxchg_q <= '0;
									state_q  <= ST_S_RD;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end
							if (!(!gp_q && i_q == clast_q)) state_q <= ST_G_RD;
						end
						if (r_q != rlast_q) state_q <= ST_G_RD;
					end
				end
				ST_S_RD: state_q <= ST_S_PIV;
				ST_S_PIV: begin
					x_q <= sol_q;
					// zero pivot leaves x and the gradient alone
					state_q <= (gram_q == '0) ? ST_S_NXT : ST_S_DW;
				end
				ST_S_DW: begin
					if (div_done) begin
						sat_q   <= sat_q | div_res.sat | subn.sat;
						t_q     <= subn.val[63] ? 64'sd0 : subn.val;
						state_q <= ST_S_T;
					end
				end
				ST_S_T: begin
					if (chg > maxchg_q) maxchg_q <= chg;
					if (t_q != x_q) begin
						delta_q <= dltn.val;
						if (dltn.sat) sat_q <= 1'b1;
						j_q     <= '0;
						state_q <= ST_U_RD;
					end else begin
						state_q <= ST_S_NXT;
					end
				end
				ST_U_RD: state_q <= ST_U_MUL;
				ST_U_MUL: begin
					gq_q    <= grad_q;
					state_q <= ST_U_MW;
				end
				ST_U_MW: begin
					if (mul_done) begin
						sat_q <= sat_q | mul_res.sat | updn.sat;
						if (j_q == clast_q) begin
							state_q <= ST_S_NXT;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_U_RD;
						end
					end
				end
				ST_S_NXT: begin
					if (i_q == clast_q) begin
						iter_q <= iter_n;
						i_q    <= '0;
						j_q    <= '0;
						if (maxchg_q <= 64'(tol_q)) begin
							conv_q  <= 1'b1;
							state_q <= ST_O_RD;
						end else if (iter_n == maxit_q) begin
							state_q <= ST_O_RD;
						end else begin
							maxchg_q <= '0;
							state_q  <= ST_S_RD;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_O_RD: state_q <= ST_O_EM;
				ST_O_EM: begin
					if (out_load) begin
						if (j_q == clast_q) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_O_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (j_q == clast_q) |=> m_tlast && m_tvalid && (state_q == ST_IDLE))
		else $error("final word not marked last");
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_G_MW || state_q == ST_U_MW))
		else $error("multiplier result with no waiting state");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_S_DW)
		else $error("divider result with no waiting state");
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_S_T |-> !t_q[63])
		else $error("new coordinate negative");

endmodule
`default_nettype wire

// File: rtl/core/nnls_coordinate_descent_solver.sv
// top level: register port, command front end and solver back end
// depends on nnls_pkg, nnls_front, nnls_engine
`default_nettype none
// Non-negative least squares solver, sequential coordinate descent on
// A^T A x = A^T b in signed Q32.32 with saturation. Matrix and rhs loads
// are taken one per cycle through a four-word command queue while it is
// not full. A solve command first forms H and mu, all through one shared
// multiplier. Each sweep then uses the bit-serial divider per column with
// a nonzero pivot and a gradient update per changed column, up to
// max_iterations sweeps. The nc results follow. While a solve runs, loads
// keep filling the queue until it is full. There is no clearing pass.
module nnls_coordinate_descent_solver import nnls_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // row[5:0], col[10:6], value[74:11], zero fill
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // index[4:0], solution[67:5], converged[68],
	                                        // iterations[84:69], zero_pivot[85],
	                                        // saturated[86], zero fill
	output logic             m_axis_tlast
);

	cfg_t cfg_q;
	logic q_valid, q_pop;
	cmd_t q_item;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows       <= 7'd64;
			cfg_q.num_cols       <= 6'd32;
			cfg_q.max_iterations <= 16'd500;
			cfg_q.tolerance      <= 32'd43;
		end else if (wr) begin
			case (paddr[3:2])
				REG_NUM_ROWS: cfg_q.num_rows       <= pwdata[6:0];
				REG_NUM_COLS: cfg_q.num_cols       <= pwdata[5:0];
				REG_MAX_ITER: cfg_q.max_iterations <= pwdata[15:0];
				REG_TOL:      cfg_q.tolerance      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_ROWS: prdata = {25'b0, cfg_q.num_rows};
			REG_NUM_COLS: prdata = {26'b0, cfg_q.num_cols};
			REG_MAX_ITER: prdata = {16'b0, cfg_q.max_iterations};
			REG_TOL:      prdata = cfg_q.tolerance;
			default:      prdata = '0;
		endcase
	end

	nnls_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	nnls_engine #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire
